// ----- rtl/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// Types, codes and helper functions shared by the grid bilinear sampler.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int DEF_MAX_COLS    = 256;
   localparam int DEF_MAX_ROWS    = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // width of the signed scratch used for cell index clamping
   localparam int IDX_W = 35;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef enum logic [2:0] {
      CMD_WRITE  = 3'd0,
      CMD_LOAD   = 3'd1,
      CMD_CONST  = 3'd2,
      CMD_READ   = 3'd3,
      CMD_SAMPLE = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_CONST = 3'd0,
      KIND_EXACT = 3'd1,
      KIND_LAT   = 3'd2,
      KIND_LON   = 3'd3,
      KIND_BILIN = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_X_MIN     = 3'd0,
      REG_X_MAX     = 3'd1,
      REG_Y_MIN     = 3'd2,
      REG_Y_MAX     = 3'd3,
      REG_X_STEP    = 3'd4,
      REG_Y_STEP    = 3'd5,
      REG_COL_COUNT = 3'd6,
      REG_ROW_COUNT = 3'd7
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_IDX,
      ST_FETCH,
      ST_LOAD_OP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] lon;
      logic signed [31:0] lat;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [31:0] sample_in;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               inside_res;
      logic [2:0]         interp_kind;
      logic               not_loaded;
   } rsp_item_type;

   typedef struct packed {
      logic        ge;
      logic [30:0] rem;
   } div_step_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] i,
                                                  input logic signed [IDX_W-1:0] last);
      if (i < 0) begin
         return '0;
      end else if (i > last) begin
         return last;
      end
      return i;
   endfunction

   // one restoring step: shift in the next dividend bit, try to subtract
   function automatic div_step_type div_step(input logic [30:0] rem, input logic msb,
                                             input logic [30:0] s);
      logic [31:0]  sh;
      logic [32:0]  diff;
      div_step_type r;
      sh    = {rem, msb};
      diff  = {1'b0, sh} - {2'b00, s};
      r.ge  = !diff[32];
      r.rem = r.ge ? diff[30:0] : sh[30:0];
      return r;
   endfunction

endpackage

// ----- rtl/gbs_ram.sv -----
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual port RAM, one write and one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/grid_bilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// grid_bilinear_sampler
// Regular grid of Q16.16 samples held in one RAM, with cell write/read and
// clamped point queries answered by exact, linear or bilinear interpolation.
// ----------------------------------------------------------------------------
// Write, load and constant-mode items: one per cycle while idle, no result.
// Cell read: one per cycle while idle and the output is free; its result is
//   registered in the RAM, then in the output register.
// Point query: 64-step restoring dividers per axis, four reads on the single
//   RAM read port, up to three lerps on one 32x32 multiplier; none before load.
// Reset clears control, config registers and the loaded flag, not the grid RAM.
module grid_bilinear_sampler #(
   parameter int MAX_COLS    = gbs_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS    = gbs_pkg::DEF_MAX_ROWS,
   parameter int VALUE_WIDTH = gbs_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gbs_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gbs_pkg::rsp_item_type           rsp_item,
   input  logic                            csr_we,
   input  logic [gbs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gbs_pkg::*;

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
   localparam logic signed [IDX_W-1:0] COLS_L = IDX_W'(MAX_COLS);
   localparam logic signed [IDX_W-1:0] ROWS_L = IDX_W'(MAX_ROWS);

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [RW-1:0] y);
      return AW'(AW'(y) * AW'(MAX_COLS) + AW'(x));
   endfunction

   function automatic logic signed [63:0] ext_v(input logic signed [VALUE_WIDTH-1:0] v);
      return {{(64 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
   endfunction

   // control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rd_vld_ff, rd_vld_in;
   logic      loaded_ff, loaded_in;
   logic signed [31:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic signed [31:0] y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic [30:0] x_step_ff, x_step_in, y_step_ff, y_step_in;
   logic [8:0]  col_count_ff, col_count_in, row_count_ff, row_count_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic [1:0]  lstep_ff, lstep_in;

   // payload
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic        rd_nl_ff, rd_nl_in, rd_inside_ff, rd_inside_in;
   logic        inside_ff, inside_in;
   kind_type    kind_ff, kind_in;
   logic signed [31:0] val_ff, val_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic [30:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [63:0] quox_ff, quox_in, quoy_ff, quoy_in;
   logic [CW-1:0] ix0_ff, ix0_in, ix1_ff, ix1_in;
   logic [RW-1:0] iy0_ff, iy0_in, iy1_ff, iy1_in;
   logic [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [VALUE_WIDTH-1:0] z00_ff, z00_in, z10_ff, z10_in;
   logic signed [VALUE_WIDTH-1:0] z01_ff, z01_in, z11_ff, z11_in;
   logic signed [VALUE_WIDTH-1:0] ra_ff, ra_in, rb_ff, rb_in, la_ff, la_in;
   logic        neg_ff, neg_in;
   logic [63:0] mag_ff, mag_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] t_ff, t_in;

   // combinational helpers
   logic        accept, out_free, rd_free;
   logic signed [IDX_W-1:0] last_col, last_row;
   logic        mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
   logic [30:0] sx, sy;
   logic signed [63:0] ws;
   logic signed [IDX_W-1:0] cx_ext, cy_ext;
   logic [IDX_W-1:0] rcx, rcy, cx0, cx1, cy0, cy1;
   logic signed [31:0] pcx, pcy;
   logic [32:0] dx, dy, dxn, dyn;
   div_step_type stx, sty;
   logic [31:0] fx, fy;
   logic        ox, oy;
   logic signed [VALUE_WIDTH-1:0] op_a, op_b;
   logic [31:0] op_t;
   logic signed [63:0] diff, res64;
   logic [63:0] q64;
   logic [31:0] mul_a;
   logic [63:0] prod;

   gbs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_free  = !rd_vld_ff || out_free;
   assign accept   = req_valid && req_ready;
   assign sx = (x_step_ff == '0) ? 31'd1 : x_step_ff;
   assign sy = (y_step_ff == '0) ? 31'd1 : y_step_ff;

   always_comb begin
      if (col_count_ff == '0) begin
         last_col = '0;
      end else if (IDX_W'(col_count_ff) > COLS_L) begin
         last_col = COLS_L - 1;
      end else begin
         last_col = IDX_W'(col_count_ff) - 1;
      end
      if (row_count_ff == '0) begin
         last_row = '0;
      end else if (IDX_W'(row_count_ff) > ROWS_L) begin
         last_row = ROWS_L - 1;
      end else begin
         last_row = IDX_W'(row_count_ff) - 1;
      end
   end

   // shared multiplier: low then high half of the difference magnitude
   assign mul_a = (state_ff == ST_MUL_LO) ? mag_ff[31:0] : mag_ff[63:32];
   assign prod  = mul_a * t_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_vld_in    = rd_vld_ff && !out_free;
      loaded_in    = loaded_ff;
      x_min_in     = x_min_ff;
      x_max_in     = x_max_ff;
      y_min_in     = y_min_ff;
      y_max_in     = y_max_ff;
      x_step_in    = x_step_ff;
      y_step_in    = y_step_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      dcnt_in      = dcnt_ff;
      fcnt_in      = fcnt_ff;
      lstep_in     = lstep_ff;
      rsp_item_in  = rsp_item_ff;
      rd_nl_in     = rd_nl_ff;
      rd_inside_in = rd_inside_ff;
      inside_in    = inside_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      remx_in      = remx_ff;
      remy_in      = remy_ff;
      quox_in      = quox_ff;
      quoy_in      = quoy_ff;
      ix0_in       = ix0_ff;
      ix1_in       = ix1_ff;
      iy0_in       = iy0_ff;
      iy1_in       = iy1_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      z00_in       = z00_ff;
      z10_in       = z10_ff;
      z01_in       = z01_ff;
      z11_in       = z11_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      la_in        = la_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      t_in         = t_ff;

      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;

      // write path
      ws = {{32{req_item.sample_in[31]}}, req_item.sample_in};
      if (ws > VMAX) begin
         ws = VMAX;
      end else if (ws < VMIN) begin
         ws = VMIN;
      end
      mem_wdata = ws[VALUE_WIDTH-1:0];
      mem_waddr = cell_addr(req_item.cell_x[CW-1:0], req_item.cell_y[RW-1:0]);

      // cell read path
      cx_ext = {{(IDX_W - 16){req_item.cell_x[15]}}, req_item.cell_x};
      cy_ext = {{(IDX_W - 16){req_item.cell_y[15]}}, req_item.cell_y};
      rcx    = clamp_idx(cx_ext, last_col);
      rcy    = clamp_idx(cy_ext, last_row);
      mem_raddr = cell_addr(rcx[CW-1:0], rcy[RW-1:0]);

      // query point clamp and offset
      pcx = ($signed(req_item.lon) < x_min_ff) ? x_min_ff : $signed(req_item.lon);
      pcx = (pcx > x_max_ff) ? x_max_ff : pcx;
      pcy = ($signed(req_item.lat) < y_min_ff) ? y_min_ff : $signed(req_item.lat);
      pcy = (pcy > y_max_ff) ? y_max_ff : pcy;
      dx  = {pcx[31], pcx} - {x_min_ff[31], x_min_ff};
      dy  = {pcy[31], pcy} - {y_min_ff[31], y_min_ff};
      dxn = 33'd0 - dx;
      dyn = 33'd0 - dy;

      stx = div_step(remx_ff, quox_ff[63], sx);
      sty = div_step(remy_ff, quoy_ff[63], sy);

      fx = quox_ff[31:0];
      fy = quoy_ff[31:0];
      ox = (|fx) || (|remx_ff);
      oy = (|fy) || (|remy_ff);
      cx0 = clamp_idx({3'b000, quox_ff[63:32]}, last_col);
      cx1 = clamp_idx({3'b000, quox_ff[63:32]} + {34'd0, ox}, last_col);
      cy0 = clamp_idx({3'b000, quoy_ff[63:32]}, last_row);
      cy1 = clamp_idx({3'b000, quoy_ff[63:32]} + {34'd0, oy}, last_row);

      // lerp operand selection
      op_a = z00_ff;
      op_b = z10_ff;
      op_t = tx_ff;
      case (kind_ff)
         KIND_LAT: begin
            op_b = z01_ff;
            op_t = ty_ff;
         end
         KIND_BILIN: begin
            if (lstep_ff == 2'd1) begin
               op_a = z01_ff;
               op_b = z11_ff;
            end else if (lstep_ff == 2'd2) begin
               op_a = ra_ff;
               op_b = rb_ff;
               op_t = ty_ff;
            end
         end
         default: ;
      endcase
      diff  = ext_v(op_b) - ext_v(op_a);
      q64   = hi_ff + {32'd0, lo_ff[63:32]};
      res64 = neg_ff ? ext_v(la_ff) - $signed(q64) - $signed({63'd0, |lo_ff[31:0]})
                     : ext_v(la_ff) + $signed(q64);

      // output register: read stage first, it never overlaps a query
      if (rd_vld_ff && out_free) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.value       = rd_nl_ff ? 32'sd0 : sat32(ext_v(mem_rdata));
         rsp_item_in.inside_res  = rd_inside_ff;
         rsp_item_in.interp_kind = rd_nl_ff ? KIND_CONST : KIND_EXACT;
         rsp_item_in.not_loaded  = rd_nl_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            case (req_item.cmd)
               CMD_READ:   req_ready = rd_free;
               CMD_SAMPLE: req_ready = !rd_vld_ff;
               default:    req_ready = 1'b1;
            endcase
            if (accept) begin
               case (req_item.cmd)
                  CMD_WRITE: begin
                     mem_we = (req_item.cell_x >= 0) && (req_item.cell_x < MAX_COLS) &&
                              (req_item.cell_y >= 0) && (req_item.cell_y < MAX_ROWS);
                  end
                  CMD_LOAD:  loaded_in = 1'b1;
                  CMD_CONST: loaded_in = 1'b0;
                  CMD_READ: begin
                     mem_re       = loaded_ff;
                     rd_vld_in    = 1'b1;
                     rd_nl_in     = !loaded_ff;
                     rd_inside_in = loaded_ff && (rcx == cx_ext) && (rcy == cy_ext);
                  end
                  CMD_SAMPLE: begin
                     inside_in = ($signed(req_item.lon) >= x_min_ff) &&
                                 ($signed(req_item.lon) <= x_max_ff) &&
                                 ($signed(req_item.lat) >= y_min_ff) &&
                                 ($signed(req_item.lat) <= y_max_ff);
                     if (!loaded_ff) begin
                        val_in   = ONE_Q16;
                        kind_in  = KIND_CONST;
                        state_in = ST_DONE;
                     end else begin
                        negx_in  = dx[32];
                        negy_in  = dy[32];
                        quox_in  = {(dx[32] ? dxn[31:0] : dx[31:0]), 32'd0};
                        quoy_in  = {(dy[32] ? dyn[31:0] : dy[31:0]), 32'd0};
                        remx_in  = '0;
                        remy_in  = '0;
                        dcnt_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            remx_in = stx.rem;
            remy_in = sty.rem;
            quox_in = {quox_ff[62:0], stx.ge};
            quoy_in = {quoy_ff[62:0], sty.ge};
            dcnt_in = dcnt_ff + 6'd1;
            if (&dcnt_ff) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            // negative offset: floor index below zero, both neighbours clamp to 0
            ix0_in = negx_ff ? '0 : cx0[CW-1:0];
            ix1_in = negx_ff ? '0 : cx1[CW-1:0];
            iy0_in = negy_ff ? '0 : cy0[RW-1:0];
            iy1_in = negy_ff ? '0 : cy1[RW-1:0];
            tx_in  = negx_ff ? (~fx + {31'd0, ~|remx_ff}) : fx;
            ty_in  = negy_ff ? (~fy + {31'd0, ~|remy_ff}) : fy;
            if (!ox && !oy) begin
               kind_in = KIND_EXACT;
            end else if (!ox) begin
               kind_in = KIND_LAT;
            end else if (!oy) begin
               kind_in = KIND_LON;
            end else begin
               kind_in = KIND_BILIN;
            end
            fcnt_in  = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            mem_re = !fcnt_ff[2];
            case (fcnt_ff[1:0])
               2'd0:    mem_raddr = cell_addr(ix0_ff, iy0_ff);
               2'd1:    mem_raddr = cell_addr(ix1_ff, iy0_ff);
               2'd2:    mem_raddr = cell_addr(ix0_ff, iy1_ff);
               default: mem_raddr = cell_addr(ix1_ff, iy1_ff);
            endcase
            case (fcnt_ff)
               3'd1:    z00_in = mem_rdata;
               3'd2:    z10_in = mem_rdata;
               3'd3:    z01_in = mem_rdata;
               3'd4:    z11_in = mem_rdata;
               default: ;
            endcase
            fcnt_in = fcnt_ff + 3'd1;
            if (fcnt_ff == 3'd4) begin
               lstep_in = '0;
               if (kind_ff == KIND_EXACT) begin
                  val_in   = sat32(ext_v(z00_ff));
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LOAD_OP;
               end
            end
         end
         ST_LOAD_OP: begin
            la_in    = op_a;
            t_in     = op_t;
            neg_in   = diff[63];
            mag_in   = diff[63] ? 64'(-diff) : 64'(diff);
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            lo_in    = prod;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            hi_in    = prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (kind_ff != KIND_BILIN || lstep_ff == 2'd2) begin
               val_in   = sat32(res64);
               state_in = ST_DONE;
            end else begin
               if (lstep_ff == 2'd0) begin
                  ra_in = res64[VALUE_WIDTH-1:0];
               end else begin
                  rb_in = res64[VALUE_WIDTH-1:0];
               end
               lstep_in = lstep_ff + 2'd1;
               state_in = ST_LOAD_OP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.value       = val_ff;
               rsp_item_in.inside_res  = inside_ff;
               rsp_item_in.interp_kind = kind_ff;
               rsp_item_in.not_loaded  = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_addr)
            REG_X_MIN:     x_min_in     = csr_wdata;
            REG_X_MAX:     x_max_in     = csr_wdata;
            REG_Y_MIN:     y_min_in     = csr_wdata;
            REG_Y_MAX:     y_max_in     = csr_wdata;
            REG_X_STEP:    x_step_in    = csr_wdata[30:0];
            REG_Y_STEP:    y_step_in    = csr_wdata[30:0];
            REG_COL_COUNT: col_count_in = csr_wdata[8:0];
            REG_ROW_COUNT: row_count_in = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         loaded_ff    <= 1'b0;
         x_min_ff     <= '0;
         x_max_ff     <= '0;
         y_min_ff     <= '0;
         y_max_ff     <= '0;
         x_step_ff    <= 31'd65536;
         y_step_ff    <= 31'd65536;
         col_count_ff <= 9'd1;
         row_count_ff <= 9'd1;
         dcnt_ff      <= '0;
         fcnt_ff      <= '0;
         lstep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         loaded_ff    <= loaded_in;
         x_min_ff     <= x_min_in;
         x_max_ff     <= x_max_in;
         y_min_ff     <= y_min_in;
         y_max_ff     <= y_max_in;
         x_step_ff    <= x_step_in;
         y_step_ff    <= y_step_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         dcnt_ff      <= dcnt_in;
         fcnt_ff      <= fcnt_in;
         lstep_ff     <= lstep_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      rd_nl_ff     <= rd_nl_in;
      rd_inside_ff <= rd_inside_in;
      inside_ff    <= inside_in;
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      negx_ff      <= negx_in;
      negy_ff      <= negy_in;
      remx_ff      <= remx_in;
      remy_ff      <= remy_in;
      quox_ff      <= quox_in;
      quoy_ff      <= quoy_in;
      ix0_ff       <= ix0_in;
      ix1_ff       <= ix1_in;
      iy0_ff       <= iy0_in;
      iy1_ff       <= iy1_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      z00_ff       <= z00_in;
      z10_ff       <= z10_in;
      z01_ff       <= z01_in;
      z11_ff       <= z11_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      la_ff        <= la_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      t_ff         <= t_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sim/grid_bilinear_sampler_tb.sv -----
// ----------------------------------------------------------------------------
// grid_bilinear_sampler_tb
// Self-checking bench for the grid sampler: cell writes, loaded and constant
// modes, clamped cell reads and point queries over several grid setups,
// checked against a bit-exact predictor with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_bilinear_sampler_tb;
   import gbs_pkg::*;

   localparam int NCOLS   = DEF_MAX_COLS;
   localparam int NROWS   = DEF_MAX_ROWS;
   localparam int LIMIT   = 600000;
   localparam int SETTLE  = 200;
   localparam int LONG_HOLD = 300;
   localparam int N_RANDOM  = 330;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_bilinear_sampler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // grid model state
   logic signed [31:0] grid_mem [NCOLS*NROWS];
   bit                 cell_seen [NCOLS*NROWS];
   bit                 grid_on;
   longint             x_lo, x_hi, y_lo, y_hi;
   longint unsigned    x_pitch, y_pitch, n_cols, n_rows;

   req_item_type item_q [$];
   rsp_item_type answer_q [$];

   int  errors = 0;
   int  n_reads = 0, n_queries = 0, n_cfg = 0;
   int  kind_hits [5];
   bit  hold_req = 1'b0;
   int  cycles = 0;

   function automatic longint clamp_cell(longint i, longint unsigned cnt, longint maxn);
      longint n;
      n = (cnt == 0) ? 1 : ((longint'(cnt) > maxn) ? maxn : longint'(cnt));
      if (i < 0) return 0;
      if (i > n - 1) return n - 1;
      return i;
   endfunction

   function automatic int cell_addr(longint ix, longint iy);
      return int'(clamp_cell(iy, n_rows, NROWS) * NCOLS + clamp_cell(ix, n_cols, NCOLS));
   endfunction

   // split clamped offset into floor index and Q0.32 fraction; true if off-node
   function automatic bit split_axis(longint p, longint lo, longint hi,
                                     longint unsigned pitch, output longint idx,
                                     output longint unsigned frac);
      longint s, pc, d, q, r;
      s  = (pitch == 0) ? 1 : longint'(pitch);
      pc = (p < lo) ? lo : p;
      pc = (pc > hi) ? hi : pc;
      d  = pc - lo;
      q  = d / s;
      r  = d % s;
      if (r < 0) begin
         q = q - 1;
         r = r + s;
      end
      idx  = q;
      frac = (longint'(r) << 32) / longint'(s);
      return r != 0;
   endfunction

   function automatic longint blend(longint a, longint b, longint unsigned t);
      longint          d;
      longint unsigned m, lo, q;
      d  = b - a;
      m  = (d < 0) ? longint'(-d) : d;
      lo = (m & 64'hFFFF_FFFF) * t;
      q  = (m >> 32) * t + (lo >> 32);
      if (d >= 0) return a + longint'(q);
      return a - longint'(q) - ((lo[31:0] != 0) ? 1 : 0);
   endfunction

   function automatic longint sat_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // applies one item to the grid model; returns 1 with the answer if one is due
   function automatic bit grid_apply(req_item_type it, output rsp_item_type r);
      longint lon, lat, cx, cy, i0, j0, i1, j1, z00, z01, z10, z11, v;
      longint unsigned tx, ty;
      bit ox, oy;
      r = '0;
      lon = it.lon; lat = it.lat; cx = it.cell_x; cy = it.cell_y;
      v = 0;
      case (it.cmd)
         CMD_WRITE: begin
            if (cx >= 0 && cx < NCOLS && cy >= 0 && cy < NROWS) begin
               grid_mem[cy*NCOLS + cx]  = it.sample_in;
               cell_seen[cy*NCOLS + cx] = 1'b1;
            end
            return 0;
         end
         CMD_LOAD: begin
            grid_on = 1'b1;
            return 0;
         end
         CMD_CONST: begin
            grid_on = 1'b0;
            return 0;
         end
         CMD_READ: begin
            if (!grid_on) begin
               r.not_loaded = 1'b1;
            end else begin
               r.inside_res = (clamp_cell(cx, n_cols, NCOLS) == cx &&
                               clamp_cell(cy, n_rows, NROWS) == cy);
               v = grid_mem[cell_addr(cx, cy)];
               r.interp_kind = KIND_EXACT;
            end
         end
         CMD_SAMPLE: begin
            r.inside_res = (lon >= x_lo && lon <= x_hi && lat >= y_lo && lat <= y_hi);
            if (!grid_on) begin
               v = ONE_Q16;
               r.interp_kind = KIND_CONST;
            end else begin
               ox = split_axis(lon, x_lo, x_hi, x_pitch, i0, tx);
               oy = split_axis(lat, y_lo, y_hi, y_pitch, j0, ty);
               i1 = i0 + ox;
               j1 = j0 + oy;
               z00 = grid_mem[cell_addr(i0, j0)];
               z01 = grid_mem[cell_addr(i0, j1)];
               z10 = grid_mem[cell_addr(i1, j0)];
               z11 = grid_mem[cell_addr(i1, j1)];
               if (!ox && !oy) begin
                  v = z00; r.interp_kind = KIND_EXACT;
               end else if (!ox) begin
                  v = blend(z00, z01, ty); r.interp_kind = KIND_LAT;
               end else if (!oy) begin
                  v = blend(z00, z10, tx); r.interp_kind = KIND_LON;
               end else begin
                  v = blend(blend(z00, z10, tx), blend(z01, z11, tx), ty);
                  r.interp_kind = KIND_BILIN;
               end
            end
         end
         default: return 0;
      endcase
      r.value = 32'(sat_q16(v));
      return 1;
   endfunction

   task automatic queue_item(req_item_type it);
      rsp_item_type r;
      item_q.push_back(it);
      if (grid_apply(it, r)) begin
         answer_q.push_back(r);
         if (it.cmd == CMD_READ) n_reads++;
         else n_queries++;
         kind_hits[r.interp_kind]++;
      end
   endtask

   function automatic logic [31:0] cell_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic cell_write(int x, int y, logic [31:0] val);
      req_item_type it;
      it = '0;
      it.cmd = CMD_WRITE;
      it.cell_x = 16'(x); it.cell_y = 16'(y); it.sample_in = val;
      it.lon = $urandom; it.lat = $urandom;
      queue_item(it);
   endtask

   // fill the cell a fetch will touch, so no unwritten entry is ever read
   task automatic need_cell(longint ix, longint iy);
      int a;
      a = cell_addr(ix, iy);
      if (!cell_seen[a]) cell_write(a % NCOLS, a / NCOLS, cell_value());
   endtask

   task automatic send(req_item_type it);
      longint i0, j0;
      longint unsigned tx, ty;
      bit ox, oy;
      if (grid_on && it.cmd == CMD_READ) need_cell(it.cell_x, it.cell_y);
      if (grid_on && it.cmd == CMD_SAMPLE) begin
         ox = split_axis(it.lon, x_lo, x_hi, x_pitch, i0, tx);
         oy = split_axis(it.lat, y_lo, y_hi, y_pitch, j0, ty);
         need_cell(i0, j0);      need_cell(i0, j0 + oy);
         need_cell(i0 + ox, j0); need_cell(i0 + ox, j0 + oy);
      end
      queue_item(it);
   endtask

   task automatic send_cmd(logic [2:0] c);
      req_item_type it;
      it = '0;
      it.cmd = c;
      it.lon = $urandom; it.lat = $urandom;
      it.cell_x = 16'($urandom); it.cell_y = 16'($urandom); it.sample_in = $urandom;
      send(it);
   endtask

   task automatic send_point(logic [31:0] lon, logic [31:0] lat);
      req_item_type it;
      it = '0;
      it.cmd = CMD_SAMPLE; it.lon = lon; it.lat = lat;
      it.cell_x = 16'($urandom); it.cell_y = 16'($urandom); it.sample_in = $urandom;
      send(it);
   endtask

   task automatic send_read(logic [15:0] x, logic [15:0] y);
      req_item_type it;
      it = '0;
      it.cmd = CMD_READ; it.cell_x = x; it.cell_y = y;
      it.lon = $urandom; it.lat = $urandom; it.sample_in = $urandom;
      send(it);
   endtask

   function automatic logic [31:0] pick_coord(longint lo, longint hi,
                                              longint unsigned pitch, longint unsigned cnt);
      longint s, k;
      s = (pitch == 0) ? 1 : longint'(pitch);
      k = $urandom_range(0, (cnt == 0) ? 1 : int'(cnt));
      case ($urandom_range(0, 9))
         0, 1, 2: return 32'(lo + k * s);
         3, 4, 5, 6: return 32'(lo + k * s + ((s > 1) ? $urandom_range(1, int'(s - 1)) : 0));
         7: return 32'($urandom_range(0, 1) ? lo : hi);
         8: return $urandom;
         default: return 32'($urandom_range(0, 1) ? lo - $urandom_range(1, 1 << 18)
                                                  : hi + $urandom_range(1, 1 << 18));
      endcase
   endfunction

   task automatic wait_idle();
      while (item_q.size() != 0 || req_valid || answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(reg_type idx, logic [31:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_grid(logic [31:0] xmn, logic [31:0] xmx, logic [31:0] ymn,
                           logic [31:0] ymx, logic [31:0] xs, logic [31:0] ys,
                           logic [31:0] nc, logic [31:0] nr);
      wait_idle();
      csr_write(REG_X_MIN, xmn);  csr_write(REG_X_MAX, xmx);
      csr_write(REG_Y_MIN, ymn);  csr_write(REG_Y_MAX, ymx);
      csr_write(REG_X_STEP, xs);  csr_write(REG_Y_STEP, ys);
      csr_write(REG_COL_COUNT, nc); csr_write(REG_ROW_COUNT, nr);
      x_lo = signed'(xmn); x_hi = signed'(xmx);
      y_lo = signed'(ymn); y_hi = signed'(ymx);
      x_pitch = xs[30:0]; y_pitch = ys[30:0];
      n_cols = nc[8:0]; n_rows = nr[8:0];
      n_cfg++;
   endtask

   task automatic random_mix(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 39))
            0, 1, 2, 3: send_cmd(CMD_WRITE);
            4: send_cmd(grid_on ? CMD_CONST : CMD_LOAD);
            5: send_cmd(CMD_SAMPLE + 3'($urandom_range(1, 3)));
            6, 7, 8, 9, 10, 11, 12, 13:
               send_read($urandom_range(0, 3) == 0 ? 16'($urandom)
                         : 16'(int'($urandom_range(0, int'(n_cols))) - 1),
                         $urandom_range(0, 3) == 0 ? 16'($urandom)
                         : 16'(int'($urandom_range(0, int'(n_rows))) - 1));
            default: send_point(pick_coord(x_lo, x_hi, x_pitch, n_cols),
                                pick_coord(y_lo, y_hi, y_pitch, n_rows));
         endcase
         if (!grid_on && $urandom_range(0, 5) == 0) send_cmd(CMD_LOAD);
      end
   endtask

   // sender
   bit calm_tx = 1'b0;
   int gap_left = 0;

   function automatic int pick_gap(bit calm);
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if ($urandom_range(0, 149) == 0) calm_tx <= !calm_tx;
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
               req_item  <= item_q.pop_front();
               req_valid <= 1'b1;
               gap_left  <= pick_gap(calm_tx);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   bit calm_rx = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, actual %h", $time, rsp_item);
            end else begin
               want = answer_q.pop_front();
               if (rsp_item.value !== want.value) begin
                  errors++;
                  $display("%0t: value expected %h actual %h", $time, want.value,
                           rsp_item.value);
               end
               if (rsp_item.inside_res !== want.inside_res) begin
                  errors++;
                  $display("%0t: inside_res expected %b actual %b", $time,
                           want.inside_res, rsp_item.inside_res);
               end
               if (rsp_item.interp_kind !== want.interp_kind) begin
                  errors++;
                  $display("%0t: interp_kind expected %0d actual %0d", $time,
                           want.interp_kind, rsp_item.interp_kind);
               end
               if (rsp_item.not_loaded !== want.not_loaded) begin
                  errors++;
                  $display("%0t: not_loaded expected %b actual %b", $time,
                           want.not_loaded, rsp_item.not_loaded);
               end
            end
         end
         if ($urandom_range(0, 149) == 0) calm_rx <= !calm_rx;
         if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            stall_left <= pick_gap(calm_rx);
            rsp_ready  <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("grid_bilinear_sampler_tb: done, errors");
         $finish;
      end
   end

   initial begin
      grid_on = 1'b0;
      x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0;
      x_pitch = 65536; y_pitch = 65536; n_cols = 1; n_rows = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setup, unloaded grid: constant answers, not_loaded read, then a load, reads and constant mode again
      send_point(32'h0, 32'h0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_read(16'h0, 16'h0);
      send_cmd(CMD_SAMPLE + 3'd1);
      send_cmd(CMD_SAMPLE + 3'd2);
      send_cmd(CMD_SAMPLE + 3'd3);
      cell_write(-1, 0, 32'h1234);        // outside the store, dropped
      cell_write(NCOLS, 3, 32'h1234);
      cell_write(2, -300, 32'h1234);
      cell_write(0, 0, 32'h7FFF_FFFF);
      send_cmd(CMD_LOAD);
      send_read(16'h0, 16'h0);
      send_read(16'h8000, 16'h7FFF);      // clamped read
      send_point(32'h0, 32'h0);
      send_cmd(CMD_CONST);
      send_point(32'h0001_0000, 32'h0);

      // small grid, 5 x 4 nodes at 1.0 spacing from -3.5 / 2.0
      set_grid(32'hFFFC_8000, 32'h0000_8000, 32'h0002_0000, 32'h0005_0000,
               32'h0001_0000, 32'h0001_0000, 5, 4);
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 5; x++)
            cell_write(x, y, (x + y) % 2 ? 32'h8000_0000 : 32'h7FFF_FFFF);
      send_cmd(CMD_LOAD);
      send_point(32'hFFFD_8000, 32'h0003_0000);   // on a node
      send_point(32'hFFFD_8000, 32'h0003_4000);   // between rows
      send_point(32'hFFFD_C000, 32'h0003_0000);   // between columns
      send_point(32'hFFFD_C001, 32'h0003_BFFF);   // full bilinear
      send_point(32'h7FFF_FFFF, 32'h8000_0000);   // far outside, clamps
      send_read(16'h4, 16'h3);

      // extreme setup: widest range, largest step, inverted latitude range
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h0, 32'h100, 32'h0);
      random_mix(60);

      // finest step, an oversized column count and a full row count
      set_grid(32'h0, 32'h0000_0100, 32'hFFFF_FF00, 32'h0, 32'h1, 32'h8000_0001,
               32'h1FF, 32'h100);
      random_mix(60);

      for (int ph = 0; ph < 5; ph++) begin
         logic [31:0] xs, ys, xmn, ymn;
         int nc, nr;
         xs = $urandom_range(1, 1 << ($urandom_range(4, 30)));
         ys = $urandom_range(1, 1 << ($urandom_range(4, 30)));
         nc = $urandom_range(1, 9);
         nr = $urandom_range(1, 9);
         xmn = $urandom;
         ymn = $urandom_range(0, 1 << 24) - (1 << 23);
         set_grid(xmn, xmn + xs * (nc - 1) + $urandom_range(0, 3), ymn,
                  ymn + ys * (nr - 1), xs, ys, nc, nr);
         if (ph == 1) begin
            // receiver stops while reads keep coming
            @(posedge clock);
            hold_req <= 1'b1;
            for (int i = 0; i < 40; i++)
               send_read(16'($urandom_range(0, nc)), 16'($urandom_range(0, nr)));
         end
         random_mix((N_RANDOM - 120) / 5);
      end

      wait_idle();
      $display("covered %0d setups, %0d cell reads, %0d point queries", n_cfg, n_reads,
               n_queries);
      $display("kinds: const %0d exact %0d lat %0d lon %0d bilinear %0d", kind_hits[0],
               kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4]);
      if (errors == 0) begin
         $display("grid_bilinear_sampler_tb: done, clean");
      end else begin
         $display("grid_bilinear_sampler_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gbs_pkg.sv
rtl/gbs_ram.sv
rtl/grid_bilinear_sampler.sv
sim/grid_bilinear_sampler_tb.sv
